// ===== hdl/lbp_pkg.sv =====
// ---------------------------------------------------------------------------
// lbp_pkg
// shared types, constants and helpers of the led blink pattern player
// ---------------------------------------------------------------------------
package lbp_pkg;

    localparam int LBP_PATTERN_DEPTH = 32;

    localparam logic [15:0] STEP_PERIOD_RESET = 16'd100;

    localparam logic [7:0] CHAR_DOT        = 8'h2e;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_STEP_PERIOD = 3'd0;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_ON     = 3'd1,
        CMD_OFF    = 3'd2,
        CMD_TOGGLE = 3'd3,
        CMD_LOAD   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    // write side of the pattern store
    typedef struct packed {
        logic en;
        logic lit;
    } store_wr_t;

    function automatic logic char_lit(input logic [7:0] c);
        return (c == CHAR_DOT) || (c == CHAR_UNDERSCORE);
    endfunction

endpackage

// ===== hdl/lbp_store.sv =====
// ---------------------------------------------------------------------------
// lbp_store
// pattern store: one lit bit per element, registered read, write-first
// ---------------------------------------------------------------------------
module lbp_store
    import lbp_pkg::*;
#(
    parameter int PATTERN_DEPTH = LBP_PATTERN_DEPTH,
    localparam int IDX_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1
)
(
    input  logic             clk,
    input  store_wr_t        wr,
    input  logic [IDX_W-1:0] waddr,
    input  logic [IDX_W-1:0] raddr,
    output logic             rdata
);

    logic mem [PATTERN_DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[waddr] <= wr.lit;
        end
    end

    // same-cycle write to the read address returns the new bit
    always_ff @(posedge clk)
    begin
        if (wr.en && (waddr == raddr))
        begin
            rdata_reg <= wr.lit;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/led_blink_pattern_player.sv =====
// ---------------------------------------------------------------------------
// led_blink_pattern_player
// one LED driven by direct commands or by a played-back stored pattern
// ---------------------------------------------------------------------------
// result: written into the output register in the cycle after its request is accepted
// throughput: one request per cycle; the output register frees in the cycle it
//   is taken, so cmd_ready stays high while res_ready is high
// reset: rst_n asynchronous, clears playback, load position, LED and handshake
//   state and sets step_period to 100; the pattern store is not cleared
module led_blink_pattern_player
    import lbp_pkg::*;
#(
    parameter int PATTERN_DEPTH = LBP_PATTERN_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [2:0]            command,
    input  logic [7:0]            pattern_char,
    input  logic                  last_char,
    input  logic                  repeat_mode,
    // result channel
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  led_on,
    output logic                  pattern_active,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IDX_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int CNT_W = $clog2(PATTERN_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PATTERN_DEPTH);

    logic [15:0]      step_period_reg;
    logic [CNT_W-1:0] pattern_length_reg, pattern_length_next;
    logic [IDX_W-1:0] play_position_reg, play_position_next;
    logic [15:0]      elapsed_ticks_reg, elapsed_ticks_next;
    logic             loop_flag_reg, loop_flag_next;
    logic             led_level_reg, led_level_next;
    logic [CNT_W-1:0] load_position_reg, load_position_next;
    logic             res_valid_reg, res_valid_next;
    logic             res_led_reg, res_active_reg;

    logic             accept;
    logic             cur_lit;
    store_wr_t        store_wr;
    logic [15:0]      period;
    logic [15:0]      elapsed_inc;
    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W-1:0] load_inc;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_STEP_PERIOD) ? {16'd0, step_period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg <= STEP_PERIOD_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_STEP_PERIOD))
        begin
            step_period_reg <= pwdata[15:0];
        end
    end

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;

    lbp_store #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_store (
        .clk   (clk),
        .wr    (store_wr),
        .waddr (load_position_reg[IDX_W-1:0]),
        .raddr (play_position_next),
        .rdata (cur_lit)
    );

    assign period      = (step_period_reg == 16'd0) ? 16'd1 : step_period_reg;
    assign elapsed_inc = elapsed_ticks_reg + 16'd1;
    assign pos_inc     = CNT_W'(play_position_reg) + CNT_W'(1);
    assign load_inc    = load_position_reg + CNT_W'(1);

    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        play_position_next  = play_position_reg;
        elapsed_ticks_next  = elapsed_ticks_reg;
        loop_flag_next      = loop_flag_reg;
        led_level_next      = led_level_reg;
        load_position_next  = load_position_reg;
        store_wr            = '0;
        store_wr.lit        = char_lit(pattern_char);

        if (accept)
        begin
            case (command)
                CMD_TICK:
                begin
                    if (pattern_length_reg != '0)
                    begin
                        led_level_next     = cur_lit;
                        elapsed_ticks_next = elapsed_inc;
                        if (elapsed_inc >= period)
                        begin
                            elapsed_ticks_next = 16'd0;
                            play_position_next = pos_inc[IDX_W-1:0];
                            if (pos_inc >= pattern_length_reg)
                            begin
                                play_position_next = '0;
                                if (!loop_flag_reg)
                                begin
                                    pattern_length_next = '0;
                                    loop_flag_next      = 1'b0;
                                end
                            end
                        end
                    end
                end
                CMD_ON:     led_level_next = 1'b1;
                CMD_OFF:    led_level_next = 1'b0;
                CMD_TOGGLE: led_level_next = !led_level_reg;
                CMD_LOAD:
                begin
                    pattern_length_next = '0;
                    play_position_next  = '0;
                    elapsed_ticks_next  = 16'd0;
                    loop_flag_next      = 1'b0;
                    if (load_position_reg < DEPTH_CNT)
                    begin
                        store_wr.en        = 1'b1;
                        load_position_next = load_inc;
                    end
                    if (last_char)
                    begin
                        // a pattern that filled the store is dropped
                        if (load_position_next < DEPTH_CNT)
                        begin
                            pattern_length_next = load_position_next;
                            loop_flag_next      = repeat_mode;
                        end
                        load_position_next = '0;
                    end
                end
                CMD_CLEAR:
                begin
                    pattern_length_next = '0;
                    play_position_next  = '0;
                    elapsed_ticks_next  = 16'd0;
                    loop_flag_next      = 1'b0;
                    load_position_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            play_position_reg  <= '0;
            elapsed_ticks_reg  <= 16'd0;
            loop_flag_reg      <= 1'b0;
            led_level_reg      <= 1'b0;
            load_position_reg  <= '0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
            play_position_reg  <= play_position_next;
            elapsed_ticks_reg  <= elapsed_ticks_next;
            loop_flag_reg      <= loop_flag_next;
            led_level_reg      <= led_level_next;
            load_position_reg  <= load_position_next;
            res_valid_reg      <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_led_reg    <= led_level_next;
            res_active_reg <= (pattern_length_next != '0);
        end
    end

    assign res_valid      = res_valid_reg;
    assign led_on         = res_led_reg;
    assign pattern_active = res_active_reg;

endmodule

// ===== hdl/lbp_checker.sv =====
// ---------------------------------------------------------------------------
// lbp_checker
// port-level checks of the led blink pattern player, bound to the top level
// ---------------------------------------------------------------------------
module lbp_checker
    import lbp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [2:0] command,
    input logic       res_valid,
    input logic       res_ready,
    input logic       led_on,
    input logic       pattern_active
);

    logic cmd_take;
    assign cmd_take = cmd_valid && cmd_ready;

    // a result not taken stays with its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(led_on) && $stable(pattern_active))
        else $error("result changed while stalled");

    a_on: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && (command == CMD_ON) |=> res_valid && led_on)
        else $error("on request did not light the led");

    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && (command == CMD_OFF) |=> res_valid && !led_on)
        else $error("off request did not darken the led");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && (command == CMD_CLEAR) |=> res_valid && !pattern_active)
        else $error("clear request left a pattern playing");

endmodule

bind led_blink_pattern_player lbp_checker u_lbp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .command        (command),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .led_on         (led_on),
    .pattern_active (pattern_active)
);
